>>> design/lisp_command_prefix_stripper_macros.svh
// assertion macros used by the checker file
`ifndef LISP_COMMAND_PREFIX_STRIPPER_MACROS_SVH
`define LISP_COMMAND_PREFIX_STRIPPER_MACROS_SVH

// same-cycle implication, checked outside reset
`define LCPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define LCPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/lcps_pkg.sv
package lcps_pkg;

  // lexer modes
  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_STRING  = 2'd1,
    MODE_COMMENT = 2'd2,
    MODE_NAME    = 2'd3
  } mode_t;

  // result kinds carried on tuser
  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_NAME = 1'b1;

  // output tdata layout
  localparam int TD_BYTE_LSB  = 0;
  localparam int TD_NAME_END  = 8;
  localparam int TD_NAME_TRNC = 9;
  localparam int TD_TEXT_END  = 10;
  localparam int OUT_TD_W     = 16;

  // characters of interest
  localparam logic [7:0] CH_C_LO   = 8'h63;
  localparam logic [7:0] CH_C_UP   = 8'h43;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_BQUOTE = 8'h60;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  // tab through carriage return, or space
  function automatic logic is_space(input logic [7:0] b);
    is_space = (b == CH_SPACE) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  // bytes after which a new symbol begins
  function automatic logic starts_after(input logic [7:0] b);
    starts_after = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_NL) || (b == CH_CR) ||
                   (b == CH_LPAREN) || (b == CH_APOS) || (b == CH_BQUOTE) ||
                   (b == CH_COMMA);
  endfunction

  // letters and the punctuation allowed in a symbol
  function automatic logic is_sym_char(input logic [7:0] b);
    is_sym_char = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
                  (b == 8'h5F) || (b == 8'h2A) || (b == 8'h2B) || (b == 8'h2D) ||
                  (b == 8'h2F) || (b == 8'h3F) || (b == 8'h21) || (b == 8'h24) ||
                  (b == 8'h25) || (b == 8'h26);
  endfunction

endpackage

>>> design/lisp_command_prefix_stripper.sv
// Lisp source filter that strips "c:" / "C:" command prefixes.
// Input channel in_*: one source byte per beat in in_tdata, in_tlast on the
// final byte of a source. Output channel out_*: out_tuser 0 is a text byte,
// 1 a captured command name byte; out_tlast marks the last result caused by
// one input beat. A name is sent just before the text byte that ends it.
// Sequence: an input beat is taken in S_IDLE, then each text byte it
// releases (0 to 3 of them) goes out from S_CONSUME; a captured name is
// first read from the name memory byte by byte in S_NAME, then S_TERM
// sends the text byte that ends it. in_tready is high only while no beat
// is in work.
// Reset clears the lexer, the lookahead and the name length; the name
// memory needs no clearing since only written entries are read.
// A single output register holds each result; while the receiver stalls
// the sequencer waits and the result stays on the port.
module lisp_command_prefix_stripper #(
  parameter int MAX_NAME_LEN = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] src_byte
  input  logic                          in_tlast,   // src_last
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [7:0] out_byte, [8] name_end, [9] name_truncated, [10] text_end, rest 0
  output logic [lcps_pkg::OUT_TD_W-1:0] out_tdata,
  output logic                          out_tuser,  // result_kind
  output logic                          out_tlast   // run_last
);

  localparam int AW    = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1;
  localparam int LEN_W = $clog2(MAX_NAME_LEN + 1);
  localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_NAME_LEN);

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_CONSUME = 4'b0010,
    S_NAME    = 4'b0100,
    S_TERM    = 4'b1000
  } seq_state_t;

  // lexer state
  lcps_pkg::mode_t mode_r, mode_nxt;
  logic            esc_r, esc_nxt;
  logic            sym_r, sym_nxt;
  logic [1:0]      held_r, held_nxt;
  logic [7:0]      hold0_r, hold0_nxt;
  logic [7:0]      hold1_r, hold1_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] trim_r, trim_nxt;
  logic            ovf_r, ovf_nxt;

  // sequencer state
  seq_state_t      state_r, state_nxt;
  logic [7:0]      b_r, b_nxt;
  logic            last_r, last_nxt;
  logic [2:0]      mask_r, mask_nxt;
  logic [LEN_W-1:0] k_r, k_nxt;

  // output register
  logic            ov_r, ov_nxt;
  logic [7:0]      obyte_r, obyte_nxt;
  logic            okind_r, okind_nxt;
  logic            onend_r, onend_nxt;
  logic            ontr_r, ontr_nxt;
  logic            otend_r, otend_nxt;
  logic            olast_r, olast_nxt;

  // name memory
  logic [7:0]      name_mem [MAX_NAME_LEN];
  logic [7:0]      rd_data_r;
  logic            wr_en, rd_en;
  logic [AW-1:0]   wr_addr, rd_addr;

  // working signals
  logic            can_emit;
  logic [7:0]      in_b, cb;
  logic [2:0]      mask_pop;
  logic            use_h0, use_h1, use_b, hold_b0, hold_b1, enter_name, held_done;
  logic [1:0]      acc_held;
  logic            emit_text, do_flush, clr_name, is_term;

  assign in_b      = in_tdata[7:0];
  assign in_tready = (state_r == S_IDLE);
  assign can_emit  = !ov_r || out_tready;
  assign mask_pop  = mask_r & (mask_r - 3'd1);

  // byte under consumption: oldest pending of hold0, hold1, input byte
  always_comb begin
    if (mask_r[0]) begin
      cb = hold0_r;
    end else if (mask_r[1]) begin
      cb = hold1_r;
    end else begin
      cb = b_r;
    end
  end

  // lookahead decision for an arriving byte
  always_comb begin
    use_h0     = 1'b0;
    use_h1     = 1'b0;
    use_b      = 1'b0;
    hold_b0    = 1'b0;
    hold_b1    = 1'b0;
    enter_name = 1'b0;
    held_done  = 1'b0;
    acc_held   = held_r;
    if (mode_r == lcps_pkg::MODE_STRING || mode_r == lcps_pkg::MODE_COMMENT) begin
      use_b = 1'b1;
    end else begin
      acc_held = 2'd0;
      if (held_r == 2'd2) begin
        if (lcps_pkg::is_sym_char(in_b)) begin
          enter_name = 1'b1;
        end else begin
          use_h0 = 1'b1;
          use_h1 = 1'b1;
        end
      end else if (held_r == 2'd1) begin
        if (in_b == lcps_pkg::CH_COLON) begin
          hold_b1   = 1'b1;
          acc_held  = 2'd2;
          held_done = 1'b1;
        end else begin
          use_h0 = 1'b1;
        end
      end
      // consuming held bytes always clears the symbol-start flag
      if (!held_done) begin
        if (sym_r && !use_h0 &&
            (in_b == lcps_pkg::CH_C_LO || in_b == lcps_pkg::CH_C_UP)) begin
          hold_b0  = 1'b1;
          acc_held = 2'd1;
        end else begin
          use_b = 1'b1;
        end
      end
    end
    // end of source flushes whatever was held
    if (in_tlast) begin
      if (hold_b0) begin
        use_b = 1'b1;
      end
      if (hold_b1) begin
        use_h0 = 1'b1;
        use_b  = 1'b1;
      end
      acc_held = 2'd0;
    end
  end

  // name terminator test
  assign is_term = ((cb == lcps_pkg::CH_SPACE) && (len_r != '0)) ||
                   (cb == lcps_pkg::CH_LPAREN) || (cb == lcps_pkg::CH_NL);

  // sequencer and lexer update
  always_comb begin
    mode_nxt  = mode_r;
    esc_nxt   = esc_r;
    sym_nxt   = sym_r;
    held_nxt  = held_r;
    hold0_nxt = hold0_r;
    hold1_nxt = hold1_r;
    len_nxt   = len_r;
    trim_nxt  = trim_r;
    ovf_nxt   = ovf_r;
    state_nxt = state_r;
    b_nxt     = b_r;
    last_nxt  = last_r;
    mask_nxt  = mask_r;
    k_nxt     = k_r;
    ov_nxt    = ov_r && !out_tready;
    obyte_nxt = obyte_r;
    okind_nxt = okind_r;
    onend_nxt = onend_r;
    ontr_nxt  = ontr_r;
    otend_nxt = otend_r;
    olast_nxt = olast_r;
    wr_en     = 1'b0;
    wr_addr   = len_r[AW-1:0];
    rd_en     = 1'b0;
    rd_addr   = '0;
    emit_text = 1'b0;
    do_flush  = 1'b0;
    clr_name  = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          b_nxt    = in_b;
          last_nxt = in_tlast;
          held_nxt = acc_held;
          mask_nxt = {use_b, use_h1, use_h0};
          if (!in_tlast && hold_b0) begin
            hold0_nxt = in_b;
          end
          if (!in_tlast && hold_b1) begin
            hold1_nxt = in_b;
          end
          if (enter_name) begin
            mode_nxt = lcps_pkg::MODE_NAME;
            clr_name = 1'b1;
          end
          if ({use_b, use_h1, use_h0} == 3'b000) begin
            do_flush = in_tlast;
          end else begin
            state_nxt = S_CONSUME;
          end
        end
      end

      S_CONSUME: begin
        if (can_emit) begin
          case (mode_r)
            lcps_pkg::MODE_STRING: begin
              emit_text = 1'b1;
              if (esc_r) begin
                esc_nxt = 1'b0;
              end else if (cb == lcps_pkg::CH_BSLASH) begin
                esc_nxt = 1'b1;
              end else if (cb == lcps_pkg::CH_DQUOTE) begin
                mode_nxt = lcps_pkg::MODE_NORMAL;
                sym_nxt  = 1'b0;
              end
            end
            lcps_pkg::MODE_COMMENT: begin
              emit_text = 1'b1;
              if (cb == lcps_pkg::CH_NL) begin
                mode_nxt = lcps_pkg::MODE_NORMAL;
                sym_nxt  = 1'b1;
              end
            end
            default: begin
              if (cb == lcps_pkg::CH_DQUOTE || cb == lcps_pkg::CH_SEMI) begin
                mode_nxt  = (cb == lcps_pkg::CH_DQUOTE) ? lcps_pkg::MODE_STRING
                                                        : lcps_pkg::MODE_COMMENT;
                sym_nxt   = 1'b0;
                emit_text = 1'b1;
              end else if (mode_r == lcps_pkg::MODE_NAME && is_term) begin
                mode_nxt = lcps_pkg::MODE_NORMAL;
                sym_nxt  = lcps_pkg::starts_after(cb);
                if (trim_r != '0) begin
                  // read out the name first, then the terminator
                  rd_en     = 1'b1;
                  rd_addr   = '0;
                  k_nxt     = '0;
                  state_nxt = S_NAME;
                end else begin
                  clr_name  = 1'b1;
                  emit_text = 1'b1;
                end
              end else begin
                if (mode_r == lcps_pkg::MODE_NAME) begin
                  if (len_r < LEN_MAX) begin
                    wr_en   = 1'b1;
                    len_nxt = len_r + LEN_ONE;
                    if (!lcps_pkg::is_space(cb)) begin
                      trim_nxt = len_r + LEN_ONE;
                    end
                  end else begin
                    ovf_nxt = 1'b1;
                  end
                end
                sym_nxt   = lcps_pkg::starts_after(cb);
                emit_text = 1'b1;
              end
            end
          endcase
        end
      end

      S_NAME: begin
        // read data of entry k is in rd_data_r; fetch k+1 while it goes out
        if (can_emit) begin
          ov_nxt    = 1'b1;
          okind_nxt = lcps_pkg::KIND_NAME;
          obyte_nxt = rd_data_r;
          onend_nxt = (k_r + LEN_ONE == trim_r);
          ontr_nxt  = ovf_r;
          otend_nxt = 1'b0;
          olast_nxt = 1'b0;
          if (k_r + LEN_ONE == trim_r) begin
            clr_name  = 1'b1;
            state_nxt = S_TERM;
          end else begin
            rd_en   = 1'b1;
            rd_addr = k_r[AW-1:0] + AW'(1);
            k_nxt   = k_r + LEN_ONE;
          end
        end
      end

      S_TERM: begin
        if (can_emit) begin
          emit_text = 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // text result of the byte under consumption
    if (emit_text) begin
      ov_nxt    = 1'b1;
      okind_nxt = lcps_pkg::KIND_TEXT;
      obyte_nxt = cb;
      onend_nxt = 1'b0;
      ontr_nxt  = 1'b0;
      otend_nxt = (mask_pop == 3'b000) && last_r;
      olast_nxt = (mask_pop == 3'b000);
      mask_nxt  = mask_pop;
      if (mask_pop == 3'b000) begin
        state_nxt = S_IDLE;
        do_flush  = last_r;
      end else begin
        state_nxt = S_CONSUME;
      end
    end

    if (clr_name) begin
      len_nxt  = '0;
      trim_nxt = '0;
      ovf_nxt  = 1'b0;
    end

    // end of source: back to reset state
    if (do_flush) begin
      mode_nxt = lcps_pkg::MODE_NORMAL;
      esc_nxt  = 1'b0;
      sym_nxt  = 1'b1;
      held_nxt = 2'd0;
      len_nxt  = '0;
      trim_nxt = '0;
      ovf_nxt  = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= lcps_pkg::MODE_NORMAL;
      esc_r   <= 1'b0;
      sym_r   <= 1'b1;
      held_r  <= 2'd0;
      len_r   <= '0;
      trim_r  <= '0;
      ovf_r   <= 1'b0;
      state_r <= S_IDLE;
      mask_r  <= 3'b000;
      ov_r    <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      esc_r   <= esc_nxt;
      sym_r   <= sym_nxt;
      held_r  <= held_nxt;
      len_r   <= len_nxt;
      trim_r  <= trim_nxt;
      ovf_r   <= ovf_nxt;
      state_r <= state_nxt;
      mask_r  <= mask_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    hold0_r <= hold0_nxt;
    hold1_r <= hold1_nxt;
    b_r     <= b_nxt;
    last_r  <= last_nxt;
    k_r     <= k_nxt;
    obyte_r <= obyte_nxt;
    okind_r <= okind_nxt;
    onend_r <= onend_nxt;
    ontr_r  <= ontr_nxt;
    otend_r <= otend_nxt;
    olast_r <= olast_nxt;
  end

  // name memory: appends and read-out never share a cycle, and every read
  // comes after the last append has been written, so no bypass is needed
  always_ff @(posedge clk) begin
    if (wr_en) begin
      name_mem[wr_addr] <= cb;
    end
    if (rd_en) begin
      rd_data_r <= name_mem[rd_addr];
    end
  end

  // output port
  assign out_tvalid = ov_r;
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;
  always_comb begin
    out_tdata = '0;
    out_tdata[lcps_pkg::TD_BYTE_LSB +: 8]  = obyte_r;
    out_tdata[lcps_pkg::TD_NAME_END]       = onend_r;
    out_tdata[lcps_pkg::TD_NAME_TRNC]      = ontr_r;
    out_tdata[lcps_pkg::TD_TEXT_END]       = otend_r;
  end

endmodule

>>> design/lcps_checker.sv
`include "lisp_command_prefix_stripper_macros.svh"

module lcps_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [lcps_pkg::OUT_TD_W-1:0] out_tdata,
  input logic                          out_tuser,
  input logic                          out_tlast
);

  // a stalled result beat holds
  `LCPS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast),
    "result beat changed while stalled")

  // end of text closes the run and is a text beat
  `LCPS_ASSERT_NOW(a_text_end_last, out_tvalid && out_tdata[lcps_pkg::TD_TEXT_END],
    out_tlast && (out_tuser == lcps_pkg::KIND_TEXT),
    "text end without run end")

  // a name beat never ends a run or the text
  `LCPS_ASSERT_NOW(a_name_not_last, out_tvalid && (out_tuser == lcps_pkg::KIND_NAME),
    !out_tlast && !out_tdata[lcps_pkg::TD_TEXT_END],
    "name beat ends a run")

  // name flags only on name beats
  `LCPS_ASSERT_NOW(a_text_flags, out_tvalid && (out_tuser == lcps_pkg::KIND_TEXT),
    !out_tdata[lcps_pkg::TD_NAME_END] && !out_tdata[lcps_pkg::TD_NAME_TRNC],
    "name flag on a text beat")

endmodule

bind lisp_command_prefix_stripper lcps_checker u_lcps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
